/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define NPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("npr assertion failed");

// check a property on every clock edge, reset included
`define NPR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("npr assertion failed");

`endif

/* sv/npr_pkg.sv */
`default_nettype none
package npr_pkg;

  localparam int DATA_W     = 32;
  localparam int NCOEF      = 7;
  localparam int MAX_DEGREE = 6;
  localparam int MAX_STEPS  = 4;
  localparam int FRAC_BITS  = 16;
  localparam int DEC_SCALE  = 10000;
  localparam int IDX_W      = 3;
  localparam int STEP_W     = 3;
  localparam int WIDE_W     = 50;
  localparam int QUO_W      = DATA_W + FRAC_BITS;

  localparam logic [1:0] POLY_P  = 2'd0;
  localparam logic [1:0] POLY_D1 = 2'd1;
  localparam logic [1:0] POLY_D2 = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic       load;
    logic       horn_start;
    logic [1:0] horn_poly;
    logic       save_p;
    logic       sel_start;
    logic       dec_old;
    logic       set_zero;
    logic       set_conv;
    logic       div_start;
    logic       update;
    logic       advance;
    logic       emit;
  } npr_cmd_t;

  typedef struct packed {
    logic horn_busy;
    logic div_busy;
    logic acc_zero;
    logic dec_eq;
    logic steps_max;
    logic out_busy;
  } npr_stat_t;

  function automatic logic ovf32(input wide_t v);
    return !((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]));
  endfunction

  function automatic word_t sat32(input wide_t v);
    if (!ovf32(v)) begin
      return v[DATA_W-1:0];
    end
    return v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic wide_t sext(input word_t v);
    return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

/* sv/npr_ifs.sv */
`default_nettype none
interface npr_in_if;
  import npr_pkg::*;
  logic  valid;
  logic  ready;
  word_t left_end;
  word_t right_end;
  modport source (output valid, output left_end, output right_end, input ready);
  modport sink (input valid, input left_end, input right_end, output ready);
endinterface

interface npr_out_if;
  import npr_pkg::*;
  logic              valid;
  logic              ready;
  word_t             root_estimate;
  logic              converged;
  logic [STEP_W-1:0] steps_used;
  logic              slope_zero;
  logic              saturated;
  modport source (output valid, output root_estimate, output converged,
                  output steps_used, output slope_zero, output saturated, input ready);
  modport sink (input valid, input root_estimate, input converged,
                input steps_used, input slope_zero, input saturated, output ready);
endinterface
`default_nettype wire

/* sv/npr_datapath.sv */
`default_nettype none
module npr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [npr_pkg::IDX_W-1:0]     cfg_idx,
  input  wire npr_pkg::word_t                cfg_data,
  input  wire npr_pkg::word_t                in_a,
  input  wire npr_pkg::word_t                in_b,
  input  wire npr_pkg::npr_cmd_t             cmd,
  output npr_pkg::npr_stat_t                 stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output npr_pkg::word_t                     out_root,
  output logic                               out_conv,
  output logic [npr_pkg::STEP_W-1:0]         out_steps,
  output logic                               out_zero,
  output logic                               out_sat
);
  import npr_pkg::*;
  `include "assert_macros.svh"

  word_t coef_r [NCOEF];
  word_t d1 [NCOEF];
  word_t d2 [NCOEF];
  logic  dsat;

  word_t b_r, xold_r, x_r, acc_r, p_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [1:0]        poly_r;
  logic [IDX_W-1:0]  idx_r;
  logic              phase_r, horn_busy_r;
  logic signed [30:0] dec_old_r;
  logic [STEP_W-1:0] steps_r;
  logic              conv_r, zero_r, sat_r;
  logic [DATA_W:0]   rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [5:0]        cnt_r;
  logic              div_busy_r, div_neg_r;
  logic              out_valid_r;

  word_t            csel;
  wide_t            hsum;
  logic [DATA_W:0]  trial;
  logic [DATA_W:0]  rs;
  wide_t            qw, diff;
  word_t            q32;
  logic signed [30:0] dec_x;
  word_t            pabs, dabs;

  function automatic logic signed [30:0] dec_of(input word_t v);
    logic signed [46:0] m;
    logic signed [46:0] adj;
    m   = 47'(v) * 47'(DEC_SCALE);
    adj = m[46] ? m + 47'((1 << FRAC_BITS) - 1) : m;
    return adj[46:FRAC_BITS];
  endfunction

  always_comb begin
    wide_t t;
    dsat = 1'b0;
    for (int i = 0; i < NCOEF; i++) begin
      d1[i] = '0;
      d2[i] = '0;
    end
    for (int i = 0; i < MAX_DEGREE; i++) begin
      t = sext(coef_r[i+1]) * WIDE_W'(i + 1);
      d1[i] = sat32(t);
      dsat = dsat | ovf32(t);
    end
    for (int i = 0; i < MAX_DEGREE - 1; i++) begin
      t = sext(d1[i+1]) * WIDE_W'(i + 1);
      d2[i] = sat32(t);
      dsat = dsat | ovf32(t);
    end
  end

  always_comb begin
    case (poly_r)
      POLY_D1: csel = d1[idx_r];
      POLY_D2: csel = d2[idx_r];
      default: csel = coef_r[idx_r];
    endcase
    hsum = sext(word_t'(0)) + {{(WIDE_W-48){prod_r[2*DATA_W-1]}}, prod_r[2*DATA_W-1:FRAC_BITS]}
           + sext(csel);
    pabs = p_r[DATA_W-1] ? -p_r : p_r;
    dabs = acc_r[DATA_W-1] ? -acc_r : acc_r;
    rs    = {rem_r[DATA_W-1:0], quo_r[QUO_W-1]};
    trial = rs - {1'b0, dabs};
    qw   = div_neg_r ? -WIDE_W'(quo_r) : WIDE_W'(quo_r);
    q32  = sat32(qw);
    diff = sext(xold_r) - sext(q32);
    dec_x = dec_of(x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (int'(cfg_idx) < NCOEF)) begin
      coef_r[cfg_idx] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horn_busy_r <= 1'b0;
      div_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      conv_r      <= 1'b0;
      zero_r      <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      if (cmd.load) begin
        b_r     <= in_b;
        xold_r  <= in_a;
        x_r     <= in_a;
        steps_r <= '0;
        conv_r  <= 1'b0;
        zero_r  <= 1'b0;
        sat_r   <= dsat;
      end
      if (cmd.horn_start) begin
        poly_r      <= cmd.horn_poly;
        phase_r     <= 1'b0;
        horn_busy_r <= 1'b1;
        case (cmd.horn_poly)
          POLY_D1: begin
            acc_r <= d1[MAX_DEGREE-1];
            idx_r <= IDX_W'(MAX_DEGREE - 2);
          end
          POLY_D2: begin
            acc_r <= d2[MAX_DEGREE-2];
            idx_r <= IDX_W'(MAX_DEGREE - 3);
          end
          default: begin
            acc_r <= coef_r[MAX_DEGREE];
            idx_r <= IDX_W'(MAX_DEGREE - 1);
          end
        endcase
      end else if (horn_busy_r) begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          prod_r <= acc_r * xold_r;
        end else begin
          acc_r <= sat32(hsum);
          if (ovf32(hsum)) begin
            sat_r <= 1'b1;
          end
          if (idx_r == '0) begin
            horn_busy_r <= 1'b0;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
      end
      if (cmd.save_p) begin
        p_r <= acc_r;
      end
      if (cmd.sel_start && (p_r != '0) && (acc_r != '0) &&
          (p_r[DATA_W-1] != acc_r[DATA_W-1])) begin
        xold_r <= b_r;
      end
      if (cmd.dec_old) begin
        dec_old_r <= dec_of(xold_r);
      end
      if (cmd.set_zero) begin
        zero_r <= 1'b1;
      end
      if (cmd.set_conv) begin
        conv_r <= 1'b1;
      end
      if (cmd.div_start) begin
        rem_r      <= '0;
        quo_r      <= {pabs, {FRAC_BITS{1'b0}}};
        cnt_r      <= 6'(QUO_W);
        div_neg_r  <= p_r[DATA_W-1] ^ acc_r[DATA_W-1];
        div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        if (!trial[DATA_W]) begin
          rem_r <= trial;
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rs;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          div_busy_r <= 1'b0;
        end
      end
      if (cmd.update) begin
        x_r     <= sat32(diff);
        steps_r <= steps_r + 1'b1;
        if (ovf32(qw) || ovf32(diff)) begin
          sat_r <= 1'b1;
        end
      end
      if (cmd.advance) begin
        xold_r    <= x_r;
        dec_old_r <= dec_x;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_root    <= zero_r ? xold_r : x_r;
        out_conv    <= conv_r;
        out_steps   <= steps_r;
        out_zero    <= zero_r;
        out_sat     <= sat_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.horn_busy = horn_busy_r;
  assign stat.div_busy  = div_busy_r;
  assign stat.acc_zero  = (acc_r == '0);
  assign stat.dec_eq    = (dec_x == dec_old_r);
  assign stat.steps_max = (steps_r == STEP_W'(MAX_STEPS));
  assign stat.out_busy  = out_valid_r && !out_ready;

  `NPR_ASSERT(a_one_unit, !(horn_busy_r && div_busy_r))
  `NPR_ASSERT(a_step_cap, steps_r <= STEP_W'(MAX_STEPS))
  `NPR_ASSERT(a_load_clear, cmd.load |=> (steps_r == '0) && !zero_r && !conv_r)
  `NPR_ASSERT(a_emit_valid, cmd.emit |=> out_valid_r)

endmodule
`default_nettype wire

/* sv/npr_ctrl.sv */
`default_nettype none
module npr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire npr_pkg::npr_stat_t stat,
  output npr_pkg::npr_cmd_t       cmd
);
  import npr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PA    = 4'd1;
  localparam logic [3:0] S_PA_W  = 4'd2;
  localparam logic [3:0] S_PPA   = 4'd3;
  localparam logic [3:0] S_PPA_W = 4'd4;
  localparam logic [3:0] S_SEL   = 4'd5;
  localparam logic [3:0] S_DEC0  = 4'd6;
  localparam logic [3:0] S_PV    = 4'd7;
  localparam logic [3:0] S_PV_W  = 4'd8;
  localparam logic [3:0] S_DV    = 4'd9;
  localparam logic [3:0] S_DV_W  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DIV_W = 4'd12;
  localparam logic [3:0] S_UPD   = 4'd13;
  localparam logic [3:0] S_CHK   = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PA;
        end
      end
      S_PA: begin
        cmd.horn_start = 1'b1;
        cmd.horn_poly  = POLY_P;
        state_nxt      = S_PA_W;
      end
      S_PA_W: begin
        if (!stat.horn_busy) begin
          cmd.save_p = 1'b1;
          state_nxt  = S_PPA;
        end
      end
      S_PPA: begin
        cmd.horn_start = 1'b1;
        cmd.horn_poly  = POLY_D2;
        state_nxt      = S_PPA_W;
      end
      S_PPA_W: begin
        if (!stat.horn_busy) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_start = 1'b1;
        state_nxt     = S_DEC0;
      end
      S_DEC0: begin
        cmd.dec_old = 1'b1;
        state_nxt   = S_PV;
      end
      S_PV: begin
        cmd.horn_start = 1'b1;
        cmd.horn_poly  = POLY_P;
        state_nxt      = S_PV_W;
      end
      S_PV_W: begin
        if (!stat.horn_busy) begin
          cmd.save_p = 1'b1;
          state_nxt  = S_DV;
        end
      end
      S_DV: begin
        cmd.horn_start = 1'b1;
        cmd.horn_poly  = POLY_D1;
        state_nxt      = S_DV_W;
      end
      S_DV_W: begin
        if (!stat.horn_busy) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.acc_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!stat.div_busy) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (stat.dec_eq) begin
          cmd.set_conv = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = stat.steps_max ? S_DONE : S_PV;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/polynomial_newton_root.sv */
// Newton root finder for a polynomial of degree up to six, signed Q16.16.
// Write coefficients coef_0..coef_6 through cfg_we/cfg_idx/cfg_data while the
// block is idle; indexes above six are dropped. Each item on in_ch carries an
// interval [left_end, right_end]; each yields exactly one item on out_ch with
// the root estimate and the converged, steps_used, slope_zero and saturated
// flags.
// One item is worked on at a time. The polynomial is evaluated by Horner's
// rule on one shared 32x32 multiplier, with a multiply and an add phase per
// coefficient, and the quotient comes from a one-bit-per-cycle divider. An
// item first picks its start point, then runs Newton steps until it
// converges, finds a zero slope or reaches the step limit.
// in_ch.ready is high only while the block waits for an item; it returns high
// as soon as the result sits in the output register, so a new item may be
// taken while out_ch is stalled. A stalled result holds until out_ch.ready.
// Reset (rst_n low at a clock edge) clears all coefficients to zero and drops
// any item in flight or pending result.
`default_nettype none
module polynomial_newton_root (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  npr_in_if.sink                         in_ch,
  npr_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [npr_pkg::IDX_W-1:0] cfg_idx,
  input  wire npr_pkg::word_t            cfg_data
);
  import npr_pkg::*;

  npr_cmd_t  cmd;
  npr_stat_t stat;

  npr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_a      (in_ch.left_end),
    .in_b      (in_ch.right_end),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_root  (out_ch.root_estimate),
    .out_conv  (out_ch.converged),
    .out_steps (out_ch.steps_used),
    .out_zero  (out_ch.slope_zero),
    .out_sat   (out_ch.saturated)
  );

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import npr_pkg::*;

  typedef struct packed {
    word_t             root;
    logic              conv;
    logic [STEP_W-1:0] steps;
    logic              zero;
    logic              sat;
  } root_result_t;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  word_t cfg_data;

  npr_in_if  in_ch ();
  npr_out_if out_ch ();

  polynomial_newton_root u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  word_t        poly[NCOEF];
  root_result_t expected_roots[$];
  int           mismatches;
  longint       cycles;
  bit           idle_on;
  int           stall_left;
  bit           sat_flag;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return 32'sh80000000;
    end
    return word_t'(v);
  endfunction

  function automatic word_t horner_eval(input word_t c[NCOEF], input int top, input word_t x);
    longint acc;
    longint prod;
    acc = c[top];
    for (int i = top - 1; i >= 0; i--) begin
      prod = acc * longint'(x);
      acc = clamp32((prod >>> FRAC_BITS) + longint'(c[i]));
    end
    return word_t'(acc);
  endfunction

  function automatic longint dec_digits(input word_t x);
    return (longint'(x) * DEC_SCALE) / (64'sd1 <<< FRAC_BITS);
  endfunction

  function automatic root_result_t solve_interval(input word_t a, input word_t b);
    word_t d1[NCOEF];
    word_t d2[NCOEF];
    word_t pa, ppa, xold, x, pv, dv, q;
    root_result_t r;
    int steps;
    sat_flag = 1'b0;
    steps = 0;
    r = '0;
    foreach (d1[i]) begin
      d1[i] = '0;
      d2[i] = '0;
    end
    for (int i = 0; i < MAX_DEGREE; i++) d1[i] = clamp32(longint'(i + 1) * poly[i + 1]);
    for (int i = 0; i < MAX_DEGREE - 1; i++) d2[i] = clamp32(longint'(i + 1) * d1[i + 1]);
    pa = horner_eval(poly, MAX_DEGREE, a);
    ppa = horner_eval(d2, MAX_DEGREE - 2, a);
    xold = (pa != 0 && ppa != 0 && ((pa < 0) != (ppa < 0))) ? b : a;
    x = xold;
    while (steps < MAX_STEPS) begin
      pv = horner_eval(poly, MAX_DEGREE, xold);
      dv = horner_eval(d1, MAX_DEGREE - 1, xold);
      if (dv == 0) begin
        r.zero = 1'b1;
        x = xold;
        break;
      end
      q = clamp32((longint'(pv) * (64'sd1 <<< FRAC_BITS)) / longint'(dv));
      x = clamp32(longint'(xold) - longint'(q));
      steps++;
      if (dec_digits(x) == dec_digits(xold)) begin
        r.conv = 1'b1;
        break;
      end
      xold = x;
    end
    r.root = x;
    r.steps = steps[STEP_W-1:0];
    r.sat = sat_flag;
    return r;
  endfunction

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.root_estimate, out_ch.converged, out_ch.steps_used,
             out_ch.slope_zero, out_ch.saturated};
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_roots.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: root %h/%h conv %b/%b steps %0d/%0d zero %b/%b sat %b/%b",
                     want.root, got.root, want.conv, got.conv, want.steps, got.steps,
                     want.zero, got.zero, want.sat, got.sat);
        end
      end
    end
  end

  task automatic write_coef(input int idx, input word_t v);
    cfg_we <= 1'b1;
    cfg_idx <= idx[IDX_W-1:0];
    cfg_data <= v;
    if (idx < NCOEF) poly[idx] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_interval(input word_t a, input word_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_end <= a;
    in_ch.right_end <= b;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    expected_roots.push_back(solve_interval(a, b));
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic word_t near_value(input int span);
    return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
  endfunction

  task automatic load_random_poly;
    int deg;
    deg = $urandom_range(0, MAX_DEGREE);
    for (int i = 0; i < NCOEF; i++) begin
      if ($urandom_range(0, 15) == 0) write_coef(i, word_t'($urandom));
      else if (i <= deg) write_coef(i, near_value(4 << FRAC_BITS));
      else write_coef(i, '0);
    end
  endtask

  task automatic test_directed;
    word_t ends[6];
    ends = '{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh00010000, 32'shffff0000,
             32'sh00020000};
    // x^2 - 2
    write_coef(0, -32'sh00020000);
    write_coef(2, 32'sh00010000);
    foreach (ends[i]) send_interval(ends[i], ends[(i + 1) % 6]);
    send_interval(32'sh00030000, 32'sh00010000);
    drain();
    // constant: zero slope at once
    write_coef(2, '0);
    write_coef(0, 32'sh00050000);
    send_interval(32'sh00010000, 32'sh00020000);
    send_interval('0, '0);
    drain();
    // x^3 - x: p(a) zero keeps the start at a, then start choice at b
    write_coef(0, '0);
    write_coef(1, -32'sh00010000);
    write_coef(3, 32'sh00010000);
    send_interval('0, 32'sh00020000);
    send_interval(32'sh00008000, 32'sh00030000);
    send_interval(-32'sh00008000, -32'sh00030000);
    drain();
    // saturating coefficients everywhere, index seven ignored
    for (int i = 0; i < NCOEF; i++) write_coef(i, i[0] ? 32'sh7fffffff : 32'sh80000000);
    write_coef(7, 32'sh12345678);
    foreach (ends[i]) send_interval(ends[i], ends[5 - i]);
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    word_t a, b;
    for (int p = 0; p < phases; p++) begin
      load_random_poly();
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          a = word_t'($urandom);
          b = word_t'($urandom);
        end else begin
          a = near_value(10 << FRAC_BITS);
          b = near_value(10 << FRAC_BITS);
        end
        send_interval(a, b);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    idle_on = 1'b1;
    stall_left = 0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_end = '0;
    in_ch.right_end = '0;
    out_ch.ready = 1'b0;
    foreach (poly[i]) poly[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(20, 50);
    idle_on = 1'b0;
    test_random(3, 50);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* polynomial_newton_root.f */
+incdir+sv
sv/npr_pkg.sv
sv/npr_ifs.sv
sv/npr_datapath.sv
sv/npr_ctrl.sv
sv/polynomial_newton_root.sv
bench/tb.sv
